@@ rtl/core/bsp_pkg.sv @@
// Shared types, constants and brush shape tables for the brush stamp pixel writer.
package bsp_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int STRIDE_WIDTH = 16;
  localparam int DIM_WIDTH    = 13;
  localparam int ADDR_WIDTH   = 29;
  localparam int LEVEL_WIDTH  = 8;
  localparam int CODE_WIDTH   = 4;
  localparam int IDX_WIDTH    = 4;
  localparam int OFS_WIDTH    = 5;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = (STRIDE_WIDTH > DIM_WIDTH) ? STRIDE_WIDTH : DIM_WIDTH;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINE_STRIDE  = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PACKED_MODE  = 2'd3;

  localparam logic [CODE_WIDTH-1:0] SHAPE_DOT      = 4'd1;
  localparam logic [CODE_WIDTH-1:0] SHAPE_BLOCK2   = 4'd2;
  localparam logic [CODE_WIDTH-1:0] SHAPE_SQ3      = 4'd3;
  localparam logic [CODE_WIDTH-1:0] SHAPE_SQ4      = 4'd4;
  localparam logic [CODE_WIDTH-1:0] SHAPE_SQ5      = 4'd5;
  localparam logic [CODE_WIDTH-1:0] SHAPE_SQ6      = 4'd6;
  localparam logic [CODE_WIDTH-1:0] SHAPE_SQ7      = 4'd7;
  localparam logic [CODE_WIDTH-1:0] SHAPE_HPAIR    = 4'd8;
  localparam logic [CODE_WIDTH-1:0] SHAPE_VPAIR    = 4'd9;
  localparam logic [CODE_WIDTH-1:0] SHAPE_CROSS    = 4'd10;
  localparam logic [CODE_WIDTH-1:0] SHAPE_CROSS_D  = 4'd11;
  localparam logic [CODE_WIDTH-1:0] SHAPE_HLINE5   = 4'd12;
  localparam logic [CODE_WIDTH-1:0] SHAPE_DIAMOND  = 4'd13;
  localparam logic [CODE_WIDTH-1:0] SHAPE_DOTTED   = 4'd14;

  // two's complement offsets
  localparam logic [OFS_WIDTH-1:0] O_0   = 5'd0;
  localparam logic [OFS_WIDTH-1:0] O_P1  = 5'd1;
  localparam logic [OFS_WIDTH-1:0] O_P2  = 5'd2;
  localparam logic [OFS_WIDTH-1:0] O_P3  = 5'd3;
  localparam logic [OFS_WIDTH-1:0] O_P4  = 5'd4;
  localparam logic [OFS_WIDTH-1:0] O_P8  = 5'd8;
  localparam logic [OFS_WIDTH-1:0] O_P12 = 5'd12;
  localparam logic [OFS_WIDTH-1:0] O_N1  = 5'h1F;
  localparam logic [OFS_WIDTH-1:0] O_N2  = 5'h1E;
  localparam logic [OFS_WIDTH-1:0] O_N3  = 5'h1D;
  localparam logic [OFS_WIDTH-1:0] O_N4  = 5'h1C;
  localparam logic [OFS_WIDTH-1:0] O_N8  = 5'h18;
  localparam logic [OFS_WIDTH-1:0] O_N12 = 5'h14;

  typedef struct packed {
    logic [DIM_WIDTH-1:0]    width;
    logic [DIM_WIDTH-1:0]    height;
    logic [STRIDE_WIDTH-1:0] stride;
    logic                    packed_mode;
  } cfg_t;

  typedef struct packed {
    logic [OFS_WIDTH-1:0] dx;
    logic [OFS_WIDTH-1:0] dy;
  } ofs_t;

  typedef struct packed {
    logic [DIM_WIDTH-1:0]   x;
    logic [DIM_WIDTH-1:0]   y;
    logic [LEVEL_WIDTH-1:0] level;
    logic                   last;
  } pix_t;

  function automatic logic is_square(input logic [CODE_WIDTH-1:0] code);
    return (code >= SHAPE_SQ3) && (code <= SHAPE_SQ7);
  endfunction

  function automatic logic [OFS_WIDTH-1:0] square_lo(input logic [CODE_WIDTH-1:0] code);
    logic [OFS_WIDTH-1:0] r;
    case (code)
      SHAPE_SQ3, SHAPE_SQ4: r = O_N1;
      SHAPE_SQ5:            r = O_N2;
      SHAPE_SQ6, SHAPE_SQ7: r = O_N3;
      default:              r = O_0;
    endcase
    return r;
  endfunction

  function automatic logic [OFS_WIDTH-1:0] square_hi(input logic [CODE_WIDTH-1:0] code);
    logic [OFS_WIDTH-1:0] r;
    case (code)
      SHAPE_SQ3:                       r = O_P1;
      SHAPE_SQ4, SHAPE_SQ5, SHAPE_SQ6: r = O_P2;
      SHAPE_SQ7:                       r = O_P3;
      default:                         r = O_0;
    endcase
    return r;
  endfunction

  // index of the final offset of a listed shape
  function automatic logic [IDX_WIDTH-1:0] list_last(input logic [CODE_WIDTH-1:0] code);
    logic [IDX_WIDTH-1:0] r;
    case (code)
      SHAPE_BLOCK2:                r = 4'd3;
      SHAPE_HPAIR, SHAPE_VPAIR:    r = 4'd1;
      SHAPE_CROSS, SHAPE_HLINE5:   r = 4'd4;
      SHAPE_CROSS_D, SHAPE_DOTTED: r = 4'd6;
      SHAPE_DIAMOND:               r = 4'd12;
      default:                     r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic ofs_t list_offset(input logic [CODE_WIDTH-1:0] code,
                                       input logic [IDX_WIDTH-1:0] idx);
    ofs_t r;
    r = '{dx: O_0, dy: O_0};
    case (code)
      SHAPE_BLOCK2: begin
        case (idx)
          4'd1:    r = '{dx: O_P1, dy: O_0};
          4'd2:    r = '{dx: O_0, dy: O_P1};
          4'd3:    r = '{dx: O_P1, dy: O_P1};
          default: r = '{dx: O_0, dy: O_0};
        endcase
      end
      SHAPE_HPAIR: begin
        if (idx == 4'd1) r = '{dx: O_P1, dy: O_0};
      end
      SHAPE_VPAIR: begin
        if (idx == 4'd1) r = '{dx: O_0, dy: O_P1};
      end
      SHAPE_CROSS, SHAPE_CROSS_D: begin
        case (idx)
          4'd1:    r = '{dx: O_N1, dy: O_0};
          4'd2:    r = '{dx: O_P1, dy: O_0};
          4'd3:    r = '{dx: O_0, dy: O_N1};
          4'd4:    r = '{dx: O_0, dy: O_P1};
          4'd5:    r = '{dx: O_P1, dy: O_P1};
          4'd6:    r = '{dx: O_N1, dy: O_N1};
          default: r = '{dx: O_0, dy: O_0};
        endcase
      end
      SHAPE_HLINE5: begin
        case (idx)
          4'd1:    r = '{dx: O_P1, dy: O_0};
          4'd2:    r = '{dx: O_N1, dy: O_0};
          4'd3:    r = '{dx: O_P2, dy: O_0};
          4'd4:    r = '{dx: O_N2, dy: O_0};
          default: r = '{dx: O_0, dy: O_0};
        endcase
      end
      SHAPE_DIAMOND: begin
        case (idx)
          4'd1:    r = '{dx: O_P1, dy: O_0};
          4'd2:    r = '{dx: O_N1, dy: O_0};
          4'd3:    r = '{dx: O_P2, dy: O_0};
          4'd4:    r = '{dx: O_N2, dy: O_0};
          4'd5:    r = '{dx: O_0, dy: O_N1};
          4'd6:    r = '{dx: O_P1, dy: O_N1};
          4'd7:    r = '{dx: O_N1, dy: O_N1};
          4'd8:    r = '{dx: O_0, dy: O_N2};
          4'd9:    r = '{dx: O_0, dy: O_P1};
          4'd10:   r = '{dx: O_P1, dy: O_P1};
          4'd11:   r = '{dx: O_N1, dy: O_P1};
          4'd12:   r = '{dx: O_0, dy: O_P2};
          default: r = '{dx: O_0, dy: O_0};
        endcase
      end
      SHAPE_DOTTED: begin
        case (idx)
          4'd1:    r = '{dx: O_P4, dy: O_0};
          4'd2:    r = '{dx: O_N4, dy: O_0};
          4'd3:    r = '{dx: O_P8, dy: O_0};
          4'd4:    r = '{dx: O_N8, dy: O_0};
          4'd5:    r = '{dx: O_P12, dy: O_0};
          4'd6:    r = '{dx: O_N12, dy: O_0};
          default: r = '{dx: O_0, dy: O_0};
        endcase
      end
      default: r = '{dx: O_0, dy: O_0};
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/bsp_front.sv @@
// Request front end: walks the shape offsets, clips pixels and marks the final write.
module bsp_front import bsp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [CODE_WIDTH-1:0]         shape_code,
  input  logic signed [COORD_WIDTH-1:0] centre_x,
  input  logic signed [COORD_WIDTH-1:0] centre_y,
  input  logic [LEVEL_WIDTH-1:0]        level,
  input  cfg_t                          cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output pix_t                          q_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GEN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]             state;
  logic [CODE_WIDTH-1:0]  code;
  logic [COORD_WIDTH-1:0] cx;
  logic [COORD_WIDTH-1:0] cy;
  logic [LEVEL_WIDTH-1:0] lvl;
  logic [IDX_WIDTH-1:0]   idx;
  logic [OFS_WIDTH-1:0]   sdx;
  logic [OFS_WIDTH-1:0]   sdy;
  logic                   held_valid;
  logic [DIM_WIDTH-1:0]   held_x;
  logic [DIM_WIDTH-1:0]   held_y;

  logic                   square;
  logic [OFS_WIDTH-1:0]   hi;
  ofs_t                   lofs;
  logic [OFS_WIDTH-1:0]   dx;
  logic [OFS_WIDTH-1:0]   dy;
  logic [COORD_WIDTH:0]   px;
  logic [COORD_WIDTH:0]   py;
  logic                   keep;
  logic                   final_cand;
  logic                   step;

  assign square = is_square(code);
  assign hi     = square_hi(code);
  assign lofs   = list_offset(code, idx);
  assign dx     = square ? sdx : lofs.dx;
  assign dy     = square ? sdy : lofs.dy;

  assign px = {cx[COORD_WIDTH-1], cx} + {{(COORD_WIDTH+1-OFS_WIDTH){dx[OFS_WIDTH-1]}}, dx};
  assign py = {cy[COORD_WIDTH-1], cy} + {{(COORD_WIDTH+1-OFS_WIDTH){dy[OFS_WIDTH-1]}}, dy};

  assign keep = !px[COORD_WIDTH] && (px[COORD_WIDTH-1:0] < COORD_WIDTH'(cfg.width)) &&
                !py[COORD_WIDTH] && (py[COORD_WIDTH-1:0] < COORD_WIDTH'(cfg.height));

  assign final_cand = square ? ((sdx == hi) && (sdy == hi)) : (idx == list_last(code));

  assign step = !q_full;
  assign busy = (state != ST_IDLE);

  always_comb begin
    q_push = 1'b0;
    q_data = '{x: held_x, y: held_y, level: lvl, last: 1'b0};
    if (step && held_valid) begin
      if (state == ST_GEN && keep) begin
        q_push = 1'b1;
      end else if (state == ST_FLUSH) begin
        q_push      = 1'b1;
        q_data.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state      <= ST_GEN;
            held_valid <= 1'b0;
          end
        end
        ST_GEN: begin
          if (step) begin
            if (keep) held_valid <= 1'b1;
            if (final_cand) state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (step) begin
            state      <= ST_IDLE;
            held_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      code <= shape_code;
      cx   <= centre_x;
      cy   <= centre_y;
      lvl  <= level;
      idx  <= '0;
      sdx  <= square_lo(shape_code);
      sdy  <= square_lo(shape_code);
    end else if (state == ST_GEN && step) begin
      if (keep) begin
        held_x <= px[DIM_WIDTH-1:0];
        held_y <= py[DIM_WIDTH-1:0];
      end
      idx <= idx + 1'b1;
      if (sdy == hi) begin
        sdy <= square_lo(code);
        sdx <= sdx + 1'b1;
      end else begin
        sdy <= sdy + 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/bsp_queue.sv @@
// Short pixel queue between the front end and the address back end.
module bsp_queue import bsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pix_t push_data,
  input  logic pop,
  output pix_t pop_data,
  output logic empty,
  output logic full
);

  pix_t                  mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QPTR_WIDTH:0]   count;

  assign empty    = (count == '0);
  assign full     = (count == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

@@ rtl/core/bsp_back.sv @@
// Address back end: row multiply, column scale and the registered write output.
module bsp_back import bsp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   q_empty,
  input  pix_t                   q_data,
  output logic                   q_pop,
  output logic                   strobe,
  output logic [ADDR_WIDTH-1:0]  byte_address,
  output logic [LEVEL_WIDTH-1:0] write_value,
  output logic                   last_write
);

  logic                   v1;
  logic [ADDR_WIDTH-1:0]  row_ofs;
  logic [DIM_WIDTH+1:0]   col_ofs;
  logic [LEVEL_WIDTH-1:0] lvl1;
  logic                   last1;

  assign q_pop = !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v1     <= q_pop;
      strobe <= v1;
    end
  end

  always_ff @(posedge clk) begin
    row_ofs <= ADDR_WIDTH'(cfg.stride) * ADDR_WIDTH'(q_data.y);
    col_ofs <= cfg.packed_mode ? {q_data.x, 2'b00} : {2'b00, q_data.x};
    lvl1    <= q_data.level;
    last1   <= q_data.last;
    byte_address <= row_ofs + ADDR_WIDTH'(col_ofs);
    write_value  <= lvl1;
    last_write   <= last1;
  end

endmodule

@@ rtl/core/brush_stamp_pixel_writer.sv @@
// Brush stamp pixel writer top level: configuration registers, front end, queue, back end.
//
//   channel   handshake                  payload
//   request   start & !busy              shape_code, centre_x, centre_y, level
//   config    cfg_valid & cfg_ready      cfg_index, cfg_data
//   write     strobe (one cycle)         byte_address, write_value, last_write
//
// busy is high while the front end walks the shape offsets (1 to 49) and the flush state;
// the next request can be accepted in the cycle busy falls. A kept pixel is queued once
// the next kept pixel or the flush state is reached, and its write then passes the back
// end's offset and output registers; the back end drains behind busy.
// Writes cannot be held off; the queue stalls the front end only when full.
// Reset is synchronous and clears control state and configuration, frame sizes to zero.
module brush_stamp_pixel_writer import bsp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [CODE_WIDTH-1:0]         shape_code,
  input  logic signed [COORD_WIDTH-1:0] centre_x,
  input  logic signed [COORD_WIDTH-1:0] centre_y,
  input  logic [LEVEL_WIDTH-1:0]        level,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  output logic                          strobe,
  output logic [ADDR_WIDTH-1:0]         byte_address,
  output logic [LEVEL_WIDTH-1:0]        write_value,
  output logic                          last_write
);

  cfg_t cfg;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  pix_t q_in;
  pix_t q_out;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.width       <= cfg_data[DIM_WIDTH-1:0];
        REG_FRAME_HEIGHT: cfg.height      <= cfg_data[DIM_WIDTH-1:0];
        REG_LINE_STRIDE:  cfg.stride      <= cfg_data[STRIDE_WIDTH-1:0];
        REG_PACKED_MODE:  cfg.packed_mode <= cfg_data[0];
        default:          cfg <= cfg;
      endcase
    end
  end

  bsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .shape_code (shape_code),
    .centre_x   (centre_x),
    .centre_y   (centre_y),
    .level      (level),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  bsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  bsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_out),
    .q_pop        (q_pop),
    .strobe       (strobe),
    .byte_address (byte_address),
    .write_value  (write_value),
    .last_write   (last_write)
  );

endmodule

@@ dv/tb_brush_stamp_pixel_writer.sv @@
// Self-checking testbench for the brush stamp pixel writer: directed table, then random requests.
`timescale 1ns / 100ps

module tb_brush_stamp_pixel_writer;
  import bsp_pkg::*;

  localparam logic [CODE_WIDTH-1:0] SHAPE_UNDEF_LO = 4'd0;
  localparam logic [CODE_WIDTH-1:0] SHAPE_UNDEF_HI = 4'd15;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DIRECTED_ROWS  = 25;
  localparam int SEGMENTS       = 4;
  localparam int SEGMENT_ITEMS  = 15;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0]  addr;
    logic [LEVEL_WIDTH-1:0] value;
    logic                   last;
  } pixel_write_t;

  typedef enum int {CHECK_MODEL, CHECK_NONE, CHECK_SINGLE} row_check_t;

  typedef struct {
    int                    new_cfg;
    int                    fw;
    int                    fh;
    int                    stride;
    int                    pk;
    logic [CODE_WIDTH-1:0] code;
    int                    cx;
    int                    cy;
    int                    lvl;
    row_check_t            check;
    int                    addr;
  } stamp_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [CODE_WIDTH-1:0]         shape_code = '0;
  logic signed [COORD_WIDTH-1:0] centre_x = '0;
  logic signed [COORD_WIDTH-1:0] centre_y = '0;
  logic [LEVEL_WIDTH-1:0]        level = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]     cfg_data = '0;
  logic                          strobe;
  logic [ADDR_WIDTH-1:0]         byte_address;
  logic [LEVEL_WIDTH-1:0]        write_value;
  logic                          last_write;

  logic [DIM_WIDTH-1:0]    frame_w = '0;
  logic [DIM_WIDTH-1:0]    frame_h = '0;
  logic [STRIDE_WIDTH-1:0] row_stride = '0;
  logic                    cfg_packed = 1'b0;

  pixel_write_t pending_writes[$];
  pixel_write_t next_write;
  int error_count = 0;
  int cycle_count = 0;

  stamp_row_t stamp_rows [DIRECTED_ROWS] = '{
    '{0,    0,    0,     0, 0, SHAPE_DOT,         0,      0, 255, CHECK_NONE,   0},
    '{1, 8191, 8191, 65535, 1, SHAPE_DOT,      8190,   8190,   0, CHECK_SINGLE, 536764410},
    '{0,    0,    0,     0, 0, SHAPE_DOT,      8191,      0,  90, CHECK_NONE,   0},
    '{0,    0,    0,     0, 0, SHAPE_DOT,        -1,      0,  90, CHECK_NONE,   0},
    '{0,    0,    0,     0, 0, SHAPE_UNDEF_LO,    5,      5, 128, CHECK_SINGLE, 327695},
    '{0,    0,    0,     0, 0, SHAPE_UNDEF_HI,    0,      0,   1, CHECK_SINGLE, 0},
    '{0,    0,    0,     0, 0, SHAPE_DOT,     32767, -32768, 170, CHECK_NONE,   0},
    '{0,    0,    0,     0, 0, SHAPE_BLOCK2,      0,      0,  17, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_SQ3,         0,      0,  34, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_SQ4,      8190,   8190,  51, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_SQ5,       100,    100,  68, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_SQ6,         1,      1,  85, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_SQ7,         3,      3, 102, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_HPAIR,    8190,      0, 119, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_VPAIR,       0,   8190, 136, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_CROSS,       0,      0, 153, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_CROSS_D,  4000,    200, 187, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_HLINE5,      1,      9, 204, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_DIAMOND,     1,      1, 221, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_DOTTED,     11,      2, 238, CHECK_MODEL,  0},
    '{1,   20,   10,    20, 0, SHAPE_SQ7,         0,      0,  77, CHECK_MODEL,  0},
    '{0,    0,    0,     0, 0, SHAPE_DIAMOND,    19,      9,  66, CHECK_MODEL,  0},
    '{1,    0, 8191,   100, 0, SHAPE_SQ7,         3,      3,  55, CHECK_NONE,   0},
    '{1,    1,    1,     0, 0, SHAPE_SQ7,         0,      0, 255, CHECK_SINGLE, 0},
    '{0,    0,    0,     0, 0, SHAPE_DOTTED,     12,      0,   0, CHECK_SINGLE, 0}
  };

  brush_stamp_pixel_writer DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .shape_code   (shape_code),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .level        (level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .byte_address (byte_address),
    .write_value  (write_value),
    .last_write   (last_write)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d writes still expected", $time, pending_writes.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Expected framebuffer writes of one request, in emission order.
  function automatic void stamp_writes(input logic [CODE_WIDTH-1:0] code,
                                       input logic [COORD_WIDTH-1:0] cx,
                                       input logic [COORD_WIDTH-1:0] cy,
                                       input logic [LEVEL_WIDTH-1:0] lvl);
    int dxs [13];
    int dys [13];
    int dxq [$];
    int dyq [$];
    int n;
    int lo;
    int hi;
    int first_idx;
    longint x;
    longint y;
    longint ux;
    longint fw;
    longint fh;
    longint sv;
    longint addr;
    pixel_write_t w;
    fw = frame_w;
    fh = frame_h;
    sv = row_stride;
    first_idx = pending_writes.size();
    if (code >= SHAPE_SQ3 && code <= SHAPE_SQ7) begin
      case (code)
        SHAPE_SQ3: begin lo = -1; hi = 1; end
        SHAPE_SQ4: begin lo = -1; hi = 2; end
        SHAPE_SQ5: begin lo = -2; hi = 2; end
        SHAPE_SQ6: begin lo = -3; hi = 2; end
        default:   begin lo = -3; hi = 3; end
      endcase
      for (int i = lo; i <= hi; i++) begin
        for (int j = lo; j <= hi; j++) begin
          dxq.push_back(i);
          dyq.push_back(j);
        end
      end
    end else begin
      dxs = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      dys = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      case (code)
        SHAPE_BLOCK2: begin
          n = 4;
          dxs = '{0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
          dys = '{0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        end
        SHAPE_HPAIR: begin
          n = 2;
          dxs = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        end
        SHAPE_VPAIR: begin
          n = 2;
          dys = '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        end
        SHAPE_CROSS, SHAPE_CROSS_D: begin
          n = (code == SHAPE_CROSS) ? 5 : 7;
          dxs = '{0, -1, 1, 0, 0, 1, -1, 0, 0, 0, 0, 0, 0};
          dys = '{0, 0, 0, -1, 1, 1, -1, 0, 0, 0, 0, 0, 0};
        end
        SHAPE_HLINE5: begin
          n = 5;
          dxs = '{0, 1, -1, 2, -2, 0, 0, 0, 0, 0, 0, 0, 0};
        end
        SHAPE_DIAMOND: begin
          n = 13;
          dxs = '{0, 1, -1, 2, -2, 0, 1, -1, 0, 0, 1, -1, 0};
          dys = '{0, 0, 0, 0, 0, -1, -1, -1, -2, 1, 1, 1, 2};
        end
        SHAPE_DOTTED: begin
          n = 7;
          dxs = '{0, 4, -4, 8, -8, 12, -12, 0, 0, 0, 0, 0, 0};
        end
        default: n = 1;
      endcase
      for (int i = 0; i < n; i++) begin
        dxq.push_back(dxs[i]);
        dyq.push_back(dys[i]);
      end
    end
    for (int i = 0; i < dxq.size(); i++) begin
      x = longint'($signed(cx)) + dxq[i];
      y = longint'($signed(cy)) + dyq[i];
      if (x >= 0 && x < fw && y >= 0 && y < fh) begin
        ux = cfg_packed ? x * 4 : x;
        addr = ux + sv * y;
        w.addr = addr[ADDR_WIDTH-1:0];
        w.value = lvl;
        w.last = 1'b0;
        pending_writes.push_back(w);
      end
    end
    if (pending_writes.size() > first_idx)
      pending_writes[pending_writes.size() - 1].last = 1'b1;
  endfunction

  task automatic put_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                         input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_FRAME_WIDTH:  frame_w = data[DIM_WIDTH-1:0];
      REG_FRAME_HEIGHT: frame_h = data[DIM_WIDTH-1:0];
      REG_LINE_STRIDE:  row_stride = data[STRIDE_WIDTH-1:0];
      default:          cfg_packed = data[0];
    endcase
  endtask

  // Unused upper bits carry noise; the block must ignore them.
  task automatic write_config(input int fw, input int fh, input int stride, input int pk);
    logic [CFG_DATA_WIDTH-1:0] word;
    word = CFG_DATA_WIDTH'($urandom);
    word[DIM_WIDTH-1:0] = fw[DIM_WIDTH-1:0];
    put_reg(REG_FRAME_WIDTH, word);
    word = CFG_DATA_WIDTH'($urandom);
    word[DIM_WIDTH-1:0] = fh[DIM_WIDTH-1:0];
    put_reg(REG_FRAME_HEIGHT, word);
    put_reg(REG_LINE_STRIDE, stride[STRIDE_WIDTH-1:0]);
    word = CFG_DATA_WIDTH'($urandom);
    word[0] = pk[0];
    put_reg(REG_PACKED_MODE, word);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending_writes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_request(input logic [CODE_WIDTH-1:0] code,
                              input logic [COORD_WIDTH-1:0] cx,
                              input logic [COORD_WIDTH-1:0] cy,
                              input logic [LEVEL_WIDTH-1:0] lvl,
                              input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    shape_code <= code;
    centre_x <= cx;
    centre_y <= cy;
    level <= lvl;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_frame_cfg();
    int sel;
    int fw;
    int fh;
    int stride;
    int pk;
    sel = $urandom_range(0, 7);
    pk = $urandom_range(0, 1);
    stride = $urandom_range(0, 65535);
    if (sel == 0) begin
      fw = 8191;
      fh = 8191;
    end else if (sel == 1) begin
      fw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8191);
      fh = (fw == 0) ? $urandom_range(0, 8191) : 0;
    end else begin
      fw = $urandom_range(1, 64);
      fh = $urandom_range(1, 64);
      if (sel < 6)
        stride = fw * (pk ? 4 : 1) + $urandom_range(0, 16);
    end
    write_config(fw, fh, stride, pk);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe !== 1'b0) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write addr=%0d value=%0d last=%0b",
                 $time, byte_address, write_value, last_write);
        error_count++;
      end else begin
        next_write = pending_writes.pop_front();
        if (next_write.addr !== byte_address || next_write.value !== write_value ||
            next_write.last !== last_write) begin
          $display("%0t: write mismatch expected addr=%0d value=%0d last=%0b,",
                   $time, next_write.addr, next_write.value, next_write.last,
                   " got addr=%0d value=%0d last=%0b",
                   byte_address, write_value, last_write);
          error_count++;
        end
      end
    end
  end

  initial begin
    int idle_pct;
    int span;
    int coord;
    logic [CODE_WIDTH-1:0]  code;
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
    logic [LEVEL_WIDTH-1:0] lvl;
    pixel_write_t w;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stamp_rows[r]) begin
      if (stamp_rows[r].new_cfg != 0) begin
        wait_idle();
        write_config(stamp_rows[r].fw, stamp_rows[r].fh, stamp_rows[r].stride,
                     stamp_rows[r].pk);
      end
      send_request(stamp_rows[r].code, stamp_rows[r].cx[COORD_WIDTH-1:0],
                   stamp_rows[r].cy[COORD_WIDTH-1:0], stamp_rows[r].lvl[LEVEL_WIDTH-1:0], 33);
      case (stamp_rows[r].check)
        CHECK_MODEL:
          stamp_writes(stamp_rows[r].code, stamp_rows[r].cx[COORD_WIDTH-1:0],
                       stamp_rows[r].cy[COORD_WIDTH-1:0], stamp_rows[r].lvl[LEVEL_WIDTH-1:0]);
        CHECK_SINGLE: begin
          w.addr = stamp_rows[r].addr[ADDR_WIDTH-1:0];
          w.value = stamp_rows[r].lvl[LEVEL_WIDTH-1:0];
          w.last = 1'b1;
          pending_writes.push_back(w);
        end
        default: ;
      endcase
    end

    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 33 : (mode == 1) ? 73 : 0;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_idle();
        random_frame_cfg();
        for (int k = 0; k < SEGMENT_ITEMS; k++) begin
          code = CODE_WIDTH'($urandom_range(0, 15));
          lvl = LEVEL_WIDTH'($urandom_range(0, 255));
          if ($urandom_range(0, 7) == 0) begin
            cx = COORD_WIDTH'($urandom);
            cy = COORD_WIDTH'($urandom);
          end else begin
            span = frame_w + 24;
            coord = $urandom_range(0, span) - 12;
            cx = coord[COORD_WIDTH-1:0];
            span = frame_h + 24;
            coord = $urandom_range(0, span) - 12;
            cy = coord[COORD_WIDTH-1:0];
          end
          send_request(code, cx, cy, lvl, idle_pct);
          stamp_writes(code, cx, cy, lvl);
        end
      end
    end

    wait_idle();
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
